[hw/rtl/tilu_pkg.sv]
// ----------------------------------------------------------------------------
// tilu_pkg
// Shared types and constants for the table interpolation lookup block.
// ----------------------------------------------------------------------------
package tilu_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int KEY_W       = 24;
    localparam int VAL_W       = 24;
    localparam int CFG_W       = 9;
    localparam int DEPTH_W     = $clog2(TABLE_DEPTH + 1);
    localparam int CNT_W       = (DEPTH_W > CFG_W) ? DEPTH_W : CFG_W;
    localparam int MIN_ENTRIES = 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int DIV_STEPS   = VAL_W;
    localparam int STEP_W      = $clog2(DIV_STEPS);

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_SHORT = 1'b1;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    typedef struct packed {
        logic              kind;
        logic [7:0]        entry_index;
        logic [KEY_W-1:0]  entry_key;
        logic [VAL_W-1:0]  entry_value;
        logic [KEY_W-1:0]  query_key;
    } t_in_item;

    typedef struct packed {
        logic [VAL_W-1:0]  value_out;
        logic              status;
    } t_out_item;

    typedef struct packed {
        t_op               op;
        logic [IDX_W-1:0]  idx;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
    } t_cmd;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIRST,
        S_LAST,
        S_SEARCH,
        S_DIFF,
        S_MUL,
        S_DIV,
        S_FIN
    } t_back_state;

endpackage

[hw/rtl/tilu_front.sv]
// ----------------------------------------------------------------------------
// tilu_front
// Accepts input words, classifies them as load or query and drops loads to
// slots beyond the table.
// ----------------------------------------------------------------------------
module tilu_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  tilu_pkg::t_in_item i_item,
    input  logic               i_full,
    output logic               o_push,
    output tilu_pkg::t_cmd     o_cmd
);

    logic is_query;
    logic in_range;
    logic r_seen;

    assign is_query = (i_item.kind == tilu_pkg::KIND_QUERY);
    assign in_range = (tilu_pkg::CNT_W'(i_item.entry_index)
                       < tilu_pkg::CNT_W'(tilu_pkg::TABLE_DEPTH));

    // busy is held during reset so nothing is taken before the queue is clear
    assign busy   = i_full || !r_seen;
    assign o_push = start && !busy && (is_query || in_range);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else begin
            r_seen <= 1'b1;
        end
    end

    always_comb begin
        o_cmd.op    = is_query ? tilu_pkg::OP_QUERY : tilu_pkg::OP_LOAD;
        o_cmd.idx   = tilu_pkg::IDX_W'(i_item.entry_index);
        o_cmd.key   = is_query ? i_item.query_key : i_item.entry_key;
        o_cmd.value = i_item.entry_value;
    end

endmodule

[hw/rtl/tilu_queue.sv]
// ----------------------------------------------------------------------------
// tilu_queue
// Short command queue between front and back.
// ----------------------------------------------------------------------------
module tilu_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tilu_pkg::t_cmd i_data,
    output logic           o_full,
    output logic           o_valid,
    input  logic           i_pop,
    output tilu_pkg::t_cmd o_data
);

    tilu_pkg::t_cmd                r_buf [tilu_pkg::QUEUE_DEPTH];
    logic [tilu_pkg::QPTR_W-1:0]   r_wp;
    logic [tilu_pkg::QPTR_W-1:0]   r_rp;
    logic [tilu_pkg::QPTR_W:0]     r_cnt;
    logic [tilu_pkg::QPTR_W-1:0]   n_wp;
    logic [tilu_pkg::QPTR_W-1:0]   n_rp;
    logic [tilu_pkg::QPTR_W:0]     n_cnt;
    logic                          do_push;
    logic                          do_pop;

    localparam logic [tilu_pkg::QPTR_W-1:0] LAST_PTR =
        tilu_pkg::QPTR_W'(tilu_pkg::QUEUE_DEPTH - 1);

    assign o_full  = (r_cnt == (tilu_pkg::QPTR_W + 1)'(tilu_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_buf[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wp = (r_wp == LAST_PTR) ? '0 : r_wp + 1'b1;
        end
        if (do_pop) begin
            n_rp = (r_rp == LAST_PTR) ? '0 : r_rp + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_buf[r_wp] <= i_data;
        end
    end

endmodule

[hw/rtl/tilu_back.sv]
// ----------------------------------------------------------------------------
// tilu_back
// Table storage, binary search over breakpoints, multiply and bit-serial
// divide for the interpolation step.
// ----------------------------------------------------------------------------
module tilu_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [tilu_pkg::CFG_W-1:0]  i_cfg_wdata,
    input  logic                        i_valid,
    input  tilu_pkg::t_cmd              i_cmd,
    output logic                        o_pop,
    output logic                        o_strobe,
    output tilu_pkg::t_out_item         o_result
);

    localparam int KW = tilu_pkg::KEY_W;
    localparam int VW = tilu_pkg::VAL_W;
    localparam int IW = tilu_pkg::IDX_W;
    localparam int CW = tilu_pkg::CNT_W;

    tilu_pkg::t_entry          mem [tilu_pkg::TABLE_DEPTH];
    tilu_pkg::t_entry          r_rd;

    tilu_pkg::t_back_state     r_state, n_state;
    logic [CW-1:0]             r_cnt;
    logic                      r_vld, n_vld;
    tilu_pkg::t_out_item       r_res, n_res;
    logic [KW-1:0]             r_key, n_key;
    logic [KW-1:0]             r_x0, n_x0, r_x1, n_x1;
    logic [VW-1:0]             r_y0, n_y0, r_y1, n_y1;
    logic [IW-1:0]             r_lo, n_lo, r_hi, n_hi, r_mid, n_mid;
    logic [KW-1:0]             r_dx, n_dx, r_num, n_num;
    logic [VW-1:0]             r_dy, n_dy;
    logic                      r_neg, n_neg;
    logic [VW-1:0]             r_rem, n_rem, r_quo, n_quo;
    logic [tilu_pkg::STEP_W-1:0] r_step, n_step;

    logic [CW-1:0]             cfg_ext;
    logic [CW-1:0]             n_m1;
    logic                      go_hi;
    logic [IW-1:0]             srch_lo, srch_hi, srch_span, srch_mid;
    logic                      srch_more;
    logic [KW+VW-1:0]          prod;
    logic [VW:0]               trial;
    logic                      ge;
    logic [VW:0]               diff;
    logic                      mem_we;
    logic [IW-1:0]             rd_addr;

    assign cfg_ext = CW'(i_cfg_wdata);
    assign n_m1    = r_cnt - CW'(1);

    // search window update
    always_comb begin
        go_hi = (r_key < r_rd.key);
        if (r_state == tilu_pkg::S_LAST) begin
            srch_lo = '0;
            srch_hi = n_m1[IW-1:0];
        end else begin
            srch_lo = go_hi ? r_lo : r_mid;
            srch_hi = go_hi ? r_mid : r_hi;
        end
        srch_span = srch_hi - srch_lo;
        srch_mid  = srch_lo + (srch_span >> 1);
        srch_more = (srch_span > IW'(1));
    end

    assign prod  = r_num * r_dy;
    assign trial = {r_rem, r_quo[VW-1]};
    assign ge    = (trial >= {1'b0, r_dx});
    assign diff  = trial - {1'b0, r_dx};

    // next state and datapath
    always_comb begin
        n_state = r_state;
        n_vld   = 1'b0;
        n_res   = r_res;
        n_key   = r_key;
        n_x0    = r_x0;
        n_y0    = r_y0;
        n_x1    = r_x1;
        n_y1    = r_y1;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_mid   = r_mid;
        n_dx    = r_dx;
        n_num   = r_num;
        n_dy    = r_dy;
        n_neg   = r_neg;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_step  = r_step;
        unique case (r_state)
            tilu_pkg::S_IDLE: begin
                if (i_valid && i_cmd.op == tilu_pkg::OP_QUERY) begin
                    n_key = i_cmd.key;
                    if (r_cnt < CW'(tilu_pkg::MIN_ENTRIES)) begin
                        n_vld = 1'b1;
                        n_res = '{value_out: '0, status: tilu_pkg::STATUS_SHORT};
                    end else begin
                        n_state = tilu_pkg::S_FIRST;
                    end
                end
            end
            tilu_pkg::S_FIRST: begin
                if (r_key <= r_rd.key) begin
                    n_vld   = 1'b1;
                    n_res   = '{value_out: r_rd.value, status: tilu_pkg::STATUS_OK};
                    n_state = tilu_pkg::S_IDLE;
                end else begin
                    n_x0    = r_rd.key;
                    n_y0    = r_rd.value;
                    n_state = tilu_pkg::S_LAST;
                end
            end
            tilu_pkg::S_LAST: begin
                if (r_key >= r_rd.key) begin
                    n_vld   = 1'b1;
                    n_res   = '{value_out: r_rd.value, status: tilu_pkg::STATUS_OK};
                    n_state = tilu_pkg::S_IDLE;
                end else begin
                    n_x1    = r_rd.key;
                    n_y1    = r_rd.value;
                    n_lo    = srch_lo;
                    n_hi    = srch_hi;
                    n_mid   = srch_mid;
                    n_state = srch_more ? tilu_pkg::S_SEARCH : tilu_pkg::S_DIFF;
                end
            end
            tilu_pkg::S_SEARCH: begin
                if (go_hi) begin
                    n_x1 = r_rd.key;
                    n_y1 = r_rd.value;
                end else begin
                    n_x0 = r_rd.key;
                    n_y0 = r_rd.value;
                end
                n_lo    = srch_lo;
                n_hi    = srch_hi;
                n_mid   = srch_mid;
                n_state = srch_more ? tilu_pkg::S_SEARCH : tilu_pkg::S_DIFF;
            end
            tilu_pkg::S_DIFF: begin
                if (r_x1 <= r_x0) begin
                    n_vld   = 1'b1;
                    n_res   = '{value_out: r_y0, status: tilu_pkg::STATUS_OK};
                    n_state = tilu_pkg::S_IDLE;
                end else begin
                    n_dx    = r_x1 - r_x0;
                    n_num   = r_key - r_x0;
                    n_neg   = (r_y1 < r_y0);
                    n_dy    = (r_y1 < r_y0) ? (r_y0 - r_y1) : (r_y1 - r_y0);
                    n_state = tilu_pkg::S_MUL;
                end
            end
            tilu_pkg::S_MUL: begin
                // upper half is below the divisor since num < dx
                n_rem   = prod[KW+VW-1:VW];
                n_quo   = prod[VW-1:0];
                n_step  = '0;
                n_state = tilu_pkg::S_DIV;
            end
            tilu_pkg::S_DIV: begin
                n_rem  = ge ? diff[VW-1:0] : trial[VW-1:0];
                n_quo  = {r_quo[VW-2:0], ge};
                n_step = r_step + 1'b1;
                if (r_step == tilu_pkg::STEP_W'(tilu_pkg::DIV_STEPS - 1)) begin
                    n_state = tilu_pkg::S_FIN;
                end
            end
            tilu_pkg::S_FIN: begin
                n_vld   = 1'b1;
                n_res   = '{value_out: r_neg ? (r_y0 - r_quo) : (r_y0 + r_quo),
                            status: tilu_pkg::STATUS_OK};
                n_state = tilu_pkg::S_IDLE;
            end
            default: n_state = tilu_pkg::S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_pop   = (r_state == tilu_pkg::S_IDLE) && i_valid;
        mem_we  = o_pop && (i_cmd.op == tilu_pkg::OP_LOAD);
        unique case (r_state)
            tilu_pkg::S_FIRST:  rd_addr = n_m1[IW-1:0];
            tilu_pkg::S_LAST,
            tilu_pkg::S_SEARCH: rd_addr = srch_mid;
            default:            rd_addr = '0;
        endcase
    end

    assign o_strobe = r_vld;
    assign o_result = r_res;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[i_cmd.idx] <= '{key: i_cmd.key, value: i_cmd.value};
        end
        r_rd <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tilu_pkg::S_IDLE;
            r_vld   <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_vld   <= n_vld;
            if (i_cfg_we) begin
                r_cnt <= (cfg_ext > CW'(tilu_pkg::TABLE_DEPTH))
                         ? CW'(tilu_pkg::TABLE_DEPTH) : cfg_ext;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res  <= n_res;
        r_key  <= n_key;
        r_x0   <= n_x0;
        r_y0   <= n_y0;
        r_x1   <= n_x1;
        r_y1   <= n_y1;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_mid  <= n_mid;
        r_dx   <= n_dx;
        r_num  <= n_num;
        r_dy   <= n_dy;
        r_neg  <= n_neg;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_step <= n_step;
    end

    a_strobe_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld |-> (r_state == tilu_pkg::S_IDLE))
        else $error("result strobe while back end still busy");

    a_search_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tilu_pkg::S_SEARCH) |-> ((r_hi > r_lo) && ((r_hi - r_lo) > IW'(1))
            && (r_mid > r_lo) && (r_mid < r_hi)))
        else $error("search window collapsed");

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tilu_pkg::S_DIV) |-> (r_rem < r_dx))
        else $error("division remainder out of range");

endmodule

[hw/rtl/table_interp_lookup.sv]
// ----------------------------------------------------------------------------
// table_interp_lookup
// Piecewise linear interpolation over a loadable breakpoint table.
// ----------------------------------------------------------------------------
// A load word is written to the table as the back end pops it. A query gets
// the short status when fewer than two entries are in use, is clamped after
// the first read at the first key or after the second at the last key, and
// otherwise interpolates: the two end reads, one table read per binary search
// step (up to log2 of the table depth) over the single registered read port,
// a difference step, a multiply step, a restoring divider that yields one
// quotient bit per cycle and a step to apply the quotient. A two-word queue
// sits in front, so busy rises only when it is full and during reset until
// r_seen is set. Each result is shown on o_result for one cycle with o_strobe
// high and must be taken then; it is never held.
// Write entries_in_use through i_cfg_we only while no word is in flight.
// ----------------------------------------------------------------------------
module table_interp_lookup (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  tilu_pkg::t_in_item          i_item,
    output logic                        o_strobe,
    output tilu_pkg::t_out_item         o_result,
    input  logic                        i_cfg_we,
    input  logic [tilu_pkg::CFG_W-1:0]  i_cfg_wdata
);

    logic           q_push;
    logic           q_full;
    logic           q_valid;
    logic           q_pop;
    tilu_pkg::t_cmd f_cmd;
    tilu_pkg::t_cmd q_cmd;

    tilu_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_cmd   (f_cmd)
    );

    tilu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (f_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_cmd)
    );

    tilu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (q_valid),
        .i_cmd       (q_cmd),
        .o_pop       (q_pop),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

endmodule
